@@ rtl/core/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants and controller/datapath interface types for the Playfair
// digraph encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // Command field of an input beat.
  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_KEY      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_KEY_DONE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TEXT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_END      = 3'd4;

  // Alphabet and character constants.
  localparam int LETTERS  = 26;
  localparam int LETTER_W = 5;
  localparam int CHAR_W   = 8;
  localparam int OUT_CHAR_W = 7;
  localparam logic [LETTER_W-1:0] IDX_Q = 5'd16;
  localparam logic [LETTER_W-1:0] IDX_X = 5'd23;
  localparam logic [LETTER_W-1:0] IDX_LAST = 5'd25;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [OUT_CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [OUT_CHAR_W-1:0] CHAR_UPPER_Z = 7'h5A;

  // Default side length of the key square.
  localparam int DEF_SQUARE_SIDE = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wipe;        // reset the square bookkeeping and pending letter
    logic place_key;   // place the key byte on the input port
    logic walk_start;  // start the alphabetical fill
    logic walk_step;   // place one letter of the alphabetical fill
    logic hold_letter; // store the text letter as pending
    logic pair_text;   // form a pair from the pending and the text letter
    logic pair_end;    // form a pair from the pending letter and x
    logic empty_end;   // message end with no pair
    logic pos_read;    // read both letter positions
    logic cell_read;   // read both cipher cells
    logic load_out;    // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic char_lower;
    logic pending_valid;
    logic walk_last;
  } dp_sts_t;

endpackage

@@ rtl/core/pfe_ram.sv @@
// ----------------------------------------------------------------------------
// pfe_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/core/pfe_datapath.sv @@
// ----------------------------------------------------------------------------
// pfe_datapath
// Key square storage, letter bookkeeping, pair formation and the cipher
// lookup path with the result register.
// ----------------------------------------------------------------------------
module pfe_datapath #(
  parameter int SQUARE_SIDE = pfe_pkg::DEF_SQUARE_SIDE
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pfe_pkg::CHAR_W-1:0]        char_in,
  input  pfe_pkg::dp_cmd_t                  ctl,
  output pfe_pkg::dp_sts_t                  sts,
  output logic [pfe_pkg::OUT_CHAR_W-1:0]    cipher_first,
  output logic [pfe_pkg::OUT_CHAR_W-1:0]    cipher_second,
  output logic                              pair_valid,
  output logic                              line_end
);

  import pfe_pkg::*;

  localparam int CELL_COUNT = SQUARE_SIDE * SQUARE_SIDE;
  localparam int POS_W      = $clog2(CELL_COUNT);
  localparam int FILL_W     = $clog2(CELL_COUNT + 1);
  localparam int RC_W       = $clog2(SQUARE_SIDE);

  // After a wipe only q counts as used.
  localparam logic [LETTERS-1:0] USED_RESET = LETTERS'(1) << IDX_Q;

  // Row of a square position, by compares against the row starts.
  function automatic logic [RC_W-1:0] pos_row(input logic [POS_W-1:0] p);
    logic [RC_W-1:0] row;
    row = '0;
    for (int r = 1; r < SQUARE_SIDE; r++) begin
      if (p >= POS_W'(r * SQUARE_SIDE)) begin
        row = RC_W'(r);
      end
    end
    return row;
  endfunction

  // Column of a square position, given its row.
  function automatic logic [RC_W-1:0] pos_col(input logic [POS_W-1:0] p,
                                              input logic [RC_W-1:0] row);
    return RC_W'(p - POS_W'(int'(row) * SQUARE_SIDE));
  endfunction

  // Next row or column, wrapping around the square.
  function automatic logic [RC_W-1:0] wrap_inc(input logic [RC_W-1:0] v);
    return (v == RC_W'(SQUARE_SIDE - 1)) ? '0 : v + 1'b1;
  endfunction

  // Square position of a row and column.
  function automatic logic [POS_W-1:0] cell_addr(input logic [RC_W-1:0] r,
                                                 input logic [RC_W-1:0] c);
    return POS_W'(int'(r) * SQUARE_SIDE + int'(c));
  endfunction

  // Bookkeeping registers.
  logic [LETTERS-1:0]  letter_used;
  logic [FILL_W-1:0]   fill_count;
  logic [LETTER_W-1:0] pending_letter;
  logic                pending_valid;
  logic [LETTER_W-1:0] walk_idx;

  // Pair operands and lookup registers.
  logic [LETTER_W-1:0] op_a;
  logic [LETTER_W-1:0] op_b;
  logic                op_pair;
  logic                op_end;
  logic                mask_a;
  logic                mask_b;
  logic                cell_ok_a;
  logic                cell_ok_b;

  // RAM connections.
  logic [POS_W-1:0]    pos_q_a;
  logic [POS_W-1:0]    pos_q_b;
  logic [LETTER_W-1:0] cell_q_a;
  logic [LETTER_W-1:0] cell_q_b;
  logic [POS_W-1:0]    cell_raddr_a;
  logic [POS_W-1:0]    cell_raddr_b;

  // Decoded input character and placement.
  logic                char_lower;
  logic [LETTER_W-1:0] char_idx;
  logic                place_req;
  logic [LETTER_W-1:0] place_letter;
  logic                place_ok;

  // Position decode for the cipher lookup.
  logic [POS_W-1:0] pa;
  logic [POS_W-1:0] pb;
  logic [RC_W-1:0]  r1;
  logic [RC_W-1:0]  c1;
  logic [RC_W-1:0]  r2;
  logic [RC_W-1:0]  c2;

  // Character decode of the incoming byte.
  assign char_lower = (char_in >= CHAR_LOWER_A) && (char_in <= CHAR_LOWER_Z);
  assign char_idx   = LETTER_W'(char_in - CHAR_LOWER_A);

  // A letter lands in the next free cell if it is new and the square has room.
  assign place_req    = (ctl.place_key && char_lower) || ctl.walk_step;
  assign place_letter = ctl.walk_step ? walk_idx : char_idx;
  assign place_ok     = place_req && !letter_used[place_letter] &&
                        (fill_count < FILL_W'(CELL_COUNT));

  assign sts.char_lower    = char_lower;
  assign sts.pending_valid = pending_valid;
  assign sts.walk_last     = (walk_idx == IDX_LAST);

  // Control state: square bookkeeping, pending letter and fill walk.
  always_ff @(posedge clk) begin
    if (rst || ctl.wipe) begin
      letter_used    <= USED_RESET;
      fill_count     <= '0;
      pending_letter <= '0;
      pending_valid  <= 1'b0;
      walk_idx       <= '0;
    end else begin
      if (place_ok) begin
        letter_used[place_letter] <= 1'b1;
        fill_count                <= fill_count + 1'b1;
      end
      if (ctl.walk_start) begin
        walk_idx <= '0;
      end else if (ctl.walk_step) begin
        walk_idx <= walk_idx + 1'b1;
      end
      if (ctl.hold_letter) begin
        pending_letter <= char_idx;
        pending_valid  <= 1'b1;
      end else if (ctl.pair_text) begin
        // An equal pair keeps the second letter pending.
        if (char_idx != pending_letter) begin
          pending_letter <= '0;
          pending_valid  <= 1'b0;
        end
      end else if (ctl.pair_end) begin
        pending_letter <= '0;
        pending_valid  <= 1'b0;
      end
    end
  end

  // Pair operands; an equal pair takes x as its second letter.
  always_ff @(posedge clk) begin
    if (ctl.pair_text) begin
      op_a    <= pending_letter;
      op_b    <= (char_idx == pending_letter) ? IDX_X : char_idx;
      op_pair <= 1'b1;
      op_end  <= 1'b0;
    end else if (ctl.pair_end) begin
      op_a    <= pending_letter;
      op_b    <= IDX_X;
      op_pair <= 1'b1;
      op_end  <= 1'b1;
    end else if (ctl.empty_end) begin
      op_pair <= 1'b0;
      op_end  <= 1'b1;
    end
  end

  // A position never written since the last wipe reads as zero.
  always_ff @(posedge clk) begin
    if (ctl.pos_read) begin
      mask_a <= letter_used[op_a] && (op_a != IDX_Q);
      mask_b <= letter_used[op_b] && (op_b != IDX_Q);
    end
  end

  // Letter position table, written as letters are placed.
  pfe_ram #(
    .WIDTH (POS_W),
    .DEPTH (LETTERS)
  ) u_pos_ram (
    .clk     (clk),
    .we      (place_ok),
    .waddr   (place_letter),
    .wdata   (fill_count[POS_W-1:0]),
    .re      (ctl.pos_read),
    .raddr_a (op_a),
    .raddr_b (op_b),
    .rdata_a (pos_q_a),
    .rdata_b (pos_q_b)
  );

  // Row, column and cipher cell addresses of the pair.
  always_comb begin
    pa = mask_a ? pos_q_a : '0;
    pb = mask_b ? pos_q_b : '0;
    r1 = pos_row(pa);
    r2 = pos_row(pb);
    c1 = pos_col(pa, r1);
    c2 = pos_col(pb, r2);
    if (r1 == r2) begin
      cell_raddr_a = cell_addr(r1, wrap_inc(c1));
      cell_raddr_b = cell_addr(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      cell_raddr_a = cell_addr(wrap_inc(r1), c1);
      cell_raddr_b = cell_addr(wrap_inc(r2), c2);
    end else begin
      cell_raddr_a = cell_addr(r1, c2);
      cell_raddr_b = cell_addr(r2, c1);
    end
  end

  // Cells fill in order, so a cell at or past the fill count has not been
  // written since the last wipe and reads as letter a.
  always_ff @(posedge clk) begin
    if (ctl.cell_read) begin
      cell_ok_a <= (FILL_W'(cell_raddr_a) < fill_count);
      cell_ok_b <= (FILL_W'(cell_raddr_b) < fill_count);
    end
  end

  // Key square, filled row by row.
  pfe_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (CELL_COUNT)
  ) u_square_ram (
    .clk     (clk),
    .we      (place_ok),
    .waddr   (fill_count[POS_W-1:0]),
    .wdata   (place_letter),
    .re      (ctl.cell_read),
    .raddr_a (cell_raddr_a),
    .raddr_b (cell_raddr_b),
    .rdata_a (cell_q_a),
    .rdata_b (cell_q_b)
  );

  // Result register in uppercase ASCII.
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      cipher_first  <= op_pair ?
                       CHAR_UPPER_A + OUT_CHAR_W'(cell_ok_a ? cell_q_a : '0) : '0;
      cipher_second <= op_pair ?
                       CHAR_UPPER_A + OUT_CHAR_W'(cell_ok_b ? cell_q_b : '0) : '0;
      pair_valid    <= op_pair;
      line_end      <= op_end;
    end
  end

endmodule

@@ rtl/core/pfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfe_ctrl
// Controller for the Playfair encryptor: input handshake, command decode,
// alphabetical fill walk, lookup sequencing and the output valid.
// ----------------------------------------------------------------------------
module pfe_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pfe_pkg::CMD_W-1:0]   cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pfe_pkg::dp_cmd_t            ctl,
  input  pfe_pkg::dp_sts_t            sts
);

  import pfe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_POS,
    ST_CELL,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Command decode and next state.
  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_CLEAR: begin
              ctl.wipe = 1'b1;
            end
            CMD_KEY: begin
              ctl.place_key = 1'b1;
            end
            CMD_KEY_DONE: begin
              ctl.walk_start = 1'b1;
              state_next     = ST_WALK;
            end
            CMD_TEXT: begin
              if (sts.char_lower) begin
                if (sts.pending_valid) begin
                  ctl.pair_text = 1'b1;
                  state_next    = ST_POS;
                end else begin
                  ctl.hold_letter = 1'b1;
                end
              end
            end
            CMD_END: begin
              if (sts.pending_valid) begin
                ctl.pair_end = 1'b1;
                state_next   = ST_POS;
              end else begin
                ctl.empty_end = 1'b1;
                state_next    = ST_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        ctl.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_POS: begin
        ctl.pos_read = 1'b1;
        state_next   = ST_CELL;
      end
      ST_CELL: begin
        ctl.cell_read = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/playfair_digraph_encryptor_top.sv @@
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor_top
// Playfair digraph encryptor with a 5x5 key square that leaves out q.
// ----------------------------------------------------------------------------
// Each input beat carries a command and a byte. Clear, key byte, a text
// letter that only becomes pending, an ignored byte and an unused command
// are handled in the accept alone. Key done makes the controller walk all 26
// letters through the single write port of the square and position memories.
// A text letter that completes a pair, and message end with a letter pending,
// go through the accept, the position memory read, the square memory
// read (both with registered read data), and the load of the result register.
// Message end with nothing pending goes through the accept and the load. The
// result register lets the next beat in while a result waits on the output;
// a new result waits in its last step until the output side has taken the
// previous one.
module playfair_digraph_encryptor_top #(
  parameter int SQUARE_SIDE = pfe_pkg::DEF_SQUARE_SIDE
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pfe_pkg::CMD_W-1:0]         cmd,
  input  logic [pfe_pkg::CHAR_W-1:0]        char_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pfe_pkg::OUT_CHAR_W-1:0]    cipher_first,
  output logic [pfe_pkg::OUT_CHAR_W-1:0]    cipher_second,
  output logic                              pair_valid,
  output logic                              line_end
);

  import pfe_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  // Controller.
  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // Datapath.
  pfe_datapath #(
    .SQUARE_SIDE (SQUARE_SIDE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .char_in       (char_in),
    .ctl           (ctl),
    .sts           (sts),
    .cipher_first  (cipher_first),
    .cipher_second (cipher_second),
    .pair_valid    (pair_valid),
    .line_end      (line_end)
  );

endmodule

@@ rtl/core/pfe_checker.sv @@
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks for the Playfair encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module pfe_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pfe_pkg::OUT_CHAR_W-1:0]    cipher_first,
  input logic [pfe_pkg::OUT_CHAR_W-1:0]    cipher_second,
  input logic                              pair_valid,
  input logic                              line_end
);

  import pfe_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_first) &&
      $stable(cipher_second) && $stable(pair_valid) && $stable(line_end))
    else $error("result beat changed while stalled");

  // A beat without a pair only ends a message and carries zero letters.
  a_empty_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pair_valid |-> line_end && (cipher_first == '0) &&
      (cipher_second == '0))
    else $error("result beat without a pair is malformed");

  // Enciphered letters are uppercase.
  a_upper: assert property (@(posedge clk) disable iff (rst)
    out_valid && pair_valid |-> (cipher_first >= CHAR_UPPER_A) &&
      (cipher_first <= CHAR_UPPER_Z) && (cipher_second >= CHAR_UPPER_A) &&
      (cipher_second <= CHAR_UPPER_Z))
    else $error("cipher letter out of the uppercase range");

  // No result beat is shown right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind playfair_digraph_encryptor_top pfe_checker u_pfe_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .cipher_first  (cipher_first),
  .cipher_second (cipher_second),
  .pair_valid    (pair_valid),
  .line_end      (line_end)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Playfair digraph encryptor. An initial block
// queues command beats (a directed opening, then random key sessions with
// messages and some noise). A clocked driver presents them with random gaps
// and predicts each accepted beat. A clocked monitor applies random
// back-pressure and checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  localparam int SIDE = DEF_SQUARE_SIDE;
  localparam int CELLS = SIDE * SIDE;
  localparam int BEAT_GOAL = 1350;
  localparam int GAP_MAX = 17;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ERR_SHOWN = 60;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_HIGH_BIT = 8'h80;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [CHAR_W-1:0] ch;
    int unsigned       gap;
  } text_beat_t;

  typedef struct packed {
    logic [OUT_CHAR_W-1:0] first;
    logic [OUT_CHAR_W-1:0] second;
    logic                  pair_ok;
    logic                  ends_line;
  } cipher_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = CMD_CLEAR;
  logic [CHAR_W-1:0] char_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_CHAR_W-1:0] cipher_first;
  logic [OUT_CHAR_W-1:0] cipher_second;
  logic pair_valid;
  logic line_end;

  text_beat_t feed_q[$];
  cipher_pair_t cipher_due[$];
  int unsigned tx_wait;
  int unsigned rx_hold;
  int unsigned rx_calm_left;
  int unsigned tx_calm_left;
  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  int unsigned beats_counted;

  // Stimulus-side tracking, used only to keep text pairs away from an
  // incomplete square.
  bit gen_full;
  bit gen_held;
  logic [CHAR_W-1:0] gen_letter;

  // Predicted square contents and text state.
  logic [LETTER_W-1:0] key_cell [CELLS];
  logic [LETTER_W-1:0] cell_of [LETTERS];
  bit letter_taken [LETTERS];
  int unsigned cells_filled;
  logic [LETTER_W-1:0] held_letter;
  bit held;

  playfair_digraph_encryptor_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .char_in      (char_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cipher_first (cipher_first),
    .cipher_second(cipher_second),
    .pair_valid   (pair_valid),
    .line_end     (line_end)
  );

  always #5 clk = ~clk;

  // Empty square: only q counts as used, nothing placed, nothing pending.
  function automatic void sq_wipe();
    for (int i = 0; i < CELLS; i++) key_cell[i] = '0;
    for (int i = 0; i < LETTERS; i++) begin
      cell_of[i] = '0;
      letter_taken[i] = (i == IDX_Q);
    end
    cells_filled = 0;
    held_letter = '0;
    held = 1'b0;
  endfunction

  function automatic void sq_place(logic [LETTER_W-1:0] idx);
    if (letter_taken[idx] || cells_filled >= CELLS) return;
    letter_taken[idx] = 1'b1;
    cell_of[idx] = LETTER_W'(cells_filled);
    key_cell[cells_filled] = idx;
    cells_filled++;
  endfunction

  function automatic logic [OUT_CHAR_W-1:0] sq_char(int unsigned row, int unsigned col);
    int unsigned pos;
    pos = (row % SIDE) * SIDE + (col % SIDE);
    return CHAR_UPPER_A + OUT_CHAR_W'(key_cell[pos]);
  endfunction

  // Classic digraph rule: row shifts right, column shifts down, else swap columns.
  function automatic cipher_pair_t sq_encipher(logic [LETTER_W-1:0] a,
                                               logic [LETTER_W-1:0] b);
    int unsigned r1, c1, r2, c2;
    cipher_pair_t r;
    r1 = cell_of[a] / SIDE;
    c1 = cell_of[a] % SIDE;
    r2 = cell_of[b] / SIDE;
    c2 = cell_of[b] % SIDE;
    r = '0;
    if (r1 == r2) begin
      r.first = sq_char(r1, c1 + 1);
      r.second = sq_char(r2, c2 + 1);
    end else if (c1 == c2) begin
      r.first = sq_char(r1 + 1, c1);
      r.second = sq_char(r2 + 1, c2);
    end else begin
      r.first = sq_char(r1, c2);
      r.second = sq_char(r2, c1);
    end
    r.pair_ok = 1'b1;
    return r;
  endfunction

  // Advance the predicted state by one command beat.
  function automatic void sq_step(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                  output bit emits, output cipher_pair_t r);
    bit lower;
    logic [LETTER_W-1:0] idx;
    lower = (ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z);
    idx = lower ? LETTER_W'(ch - CHAR_LOWER_A) : '0;
    emits = 1'b0;
    r = '0;
    case (op)
      CMD_CLEAR: sq_wipe();
      CMD_KEY: if (lower) sq_place(idx);
      CMD_KEY_DONE: for (int i = 0; i < LETTERS; i++) sq_place(LETTER_W'(i));
      CMD_TEXT: if (lower) begin
        if (!held) begin
          held_letter = idx;
          held = 1'b1;
        end else if (held_letter == idx) begin
          // A doubled letter is split by x and stays pending.
          r = sq_encipher(held_letter, IDX_X);
          emits = 1'b1;
        end else begin
          r = sq_encipher(held_letter, idx);
          emits = 1'b1;
          held = 1'b0;
          held_letter = '0;
        end
      end
      CMD_END: begin
        if (held) r = sq_encipher(held_letter, IDX_X);
        r.ends_line = 1'b1;
        emits = 1'b1;
        held = 1'b0;
        held_letter = '0;
      end
      default: ;
    endcase
  endfunction

  // Queue one beat. Beats that would pair text against an incomplete square
  // are bent into harmless ones.
  task automatic send(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] ch);
    text_beat_t b;
    bit lower;
    lower = (ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z);
    if (op == CMD_TEXT && lower && gen_held && !gen_full) begin
      ch = ch ^ CHAR_HIGH_BIT;
      lower = 1'b0;
    end
    if (op == CMD_END && gen_held && !gen_full) op = CMD_KEY_DONE;
    case (op)
      CMD_CLEAR: begin
        gen_full = 1'b0;
        gen_held = 1'b0;
      end
      CMD_KEY_DONE: gen_full = 1'b1;
      CMD_TEXT: if (lower) begin
        if (!gen_held) begin
          gen_held = 1'b1;
          gen_letter = ch;
        end else if (gen_letter != ch) begin
          gen_held = 1'b0;
        end
      end
      CMD_END: gen_held = 1'b0;
      default: ;
    endcase
    beats_counted++;
    // Random gaps, with occasional back-to-back stretches.
    if (tx_calm_left != 0) begin
      tx_calm_left--;
      b.gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      tx_calm_left = $urandom_range(8, 40);
      b.gap = 0;
    end else begin
      b.gap = $urandom_range(0, GAP_MAX);
    end
    b.op = op;
    b.ch = ch;
    feed_q.insert(feed_q.size(), b);
  endtask

  function automatic logic [CHAR_W-1:0] key_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 16) return CHAR_LOWER_A + CHAR_W'($urandom_range(0, LETTERS - 1));
    if (r < 18) return CHAR_LOWER_A + CHAR_W'(IDX_Q);
    return CHAR_W'($urandom);
  endfunction

  // Mostly letters, with doubles, x, q, spaces and stray bytes mixed in.
  function automatic logic [CHAR_W-1:0] text_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 13) return CHAR_LOWER_A + CHAR_W'($urandom_range(0, LETTERS - 1));
    if (r < 16) return gen_held ? gen_letter
                                : CHAR_LOWER_A + CHAR_W'($urandom_range(0, LETTERS - 1));
    if (r == 16) return CHAR_LOWER_A + CHAR_W'(IDX_X);
    if (r == 17) return CHAR_LOWER_A + CHAR_W'(IDX_Q);
    if (r == 18) return CHAR_SPACE;
    return CHAR_W'($urandom);
  endfunction

  // Hold off until every queued beat is taken and every result is back.
  task automatic drain();
    while (feed_q.size() != 0 || in_valid || cipher_due.size() != 0) @(negedge clk);
  endtask

  // Driver: predicts each accepted beat and presents the next one.
  always @(posedge clk) begin
    bit emits;
    cipher_pair_t due;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
      sq_wipe();
    end else begin
      if (in_valid && in_ready) begin
        sq_step(cmd, char_in, emits, due);
        if (emits) cipher_due.insert(cipher_due.size(), due);
      end
      if (!in_valid || in_ready) begin
        if (feed_q.size() != 0 && tx_wait >= feed_q[0].gap) begin
          in_valid <= 1'b1;
          cmd <= feed_q[0].op;
          char_in <= feed_q[0].ch;
          void'(feed_q.pop_front());
          tx_wait <= 0;
        end else begin
          in_valid <= 1'b0;
          if (feed_q.size() != 0) tx_wait <= tx_wait + 1;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    int unsigned stall;
    cipher_pair_t due;
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (out_valid && out_ready) begin
      if (cipher_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= ERR_SHOWN) $error("result beat arrived with no prediction pending");
      end else begin
        due = cipher_due.pop_front();
        if (cipher_first !== due.first) begin
          fail_cnt++;
          if (fail_cnt <= ERR_SHOWN)
            $error("cipher_first: expected %0d, got %0d", due.first, cipher_first);
        end
        if (cipher_second !== due.second) begin
          fail_cnt++;
          if (fail_cnt <= ERR_SHOWN)
            $error("cipher_second: expected %0d, got %0d", due.second, cipher_second);
        end
        if (pair_valid !== due.pair_ok) begin
          fail_cnt++;
          if (fail_cnt <= ERR_SHOWN)
            $error("pair_valid: expected %0d, got %0d", due.pair_ok, pair_valid);
        end
        if (line_end !== due.ends_line) begin
          fail_cnt++;
          if (fail_cnt <= ERR_SHOWN)
            $error("line_end: expected %0d, got %0d", due.ends_line, line_end);
        end
      end
      // Draw the stall before the next result, with some stall-free stretches.
      if (rx_calm_left != 0) begin
        rx_calm_left--;
        stall = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        rx_calm_left = $urandom_range(8, 40);
        stall = 0;
      end else begin
        stall = $urandom_range(0, GAP_MAX);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        rx_hold <= stall;
      end
    end else if (!out_ready) begin
      if (rx_hold <= 1) begin
        out_ready <= 1'b1;
        rx_hold <= 0;
      end else begin
        rx_hold <= rx_hold - 1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Stimulus: directed opening, a full drain, then random sessions.
  initial begin
    // Message end with nothing pending; a pending letter dropped by clear.
    send(CMD_END, 8'hFF);
    send(CMD_TEXT, "a");
    send(CMD_CLEAR, 8'h00);
    send(CMD_END, 8'h00);
    // Key with a repeat, the left-out q, and bytes that are not lowercase.
    send(CMD_KEY, "p");
    send(CMD_KEY, "l");
    send(CMD_KEY, "a");
    send(CMD_KEY, "y");
    send(CMD_KEY, "a");
    send(CMD_KEY, "q");
    send(CMD_KEY, "E");
    send(CMD_KEY, 8'hFF);
    send(CMD_KEY, "z");
    send(CMD_KEY_DONE, 8'h00);
    // Key done on a full square places nothing.
    send(CMD_KEY_DONE, 8'hFF);
    // Text with skipped bytes, a double x, a q, and a padded last letter.
    send(CMD_TEXT, "h");
    send(CMD_TEXT, CHAR_SPACE);
    send(CMD_TEXT, 8'h00);
    send(CMD_TEXT, "l");
    send(CMD_TEXT, "x");
    send(CMD_TEXT, "x");
    send(CMD_TEXT, "q");
    send(CMD_TEXT, "m");
    send(CMD_END, 8'h00);
    // Unused commands.
    send(CMD_SPARE_LO, "a");
    send(CMD_SPARE_HI, 8'hFF);
    drain();

    while (beats_counted < BEAT_GOAL) begin
      if ($urandom_range(0, 9) < 8) begin
        if (!gen_full || $urandom_range(0, 5) != 0) begin
          send(CMD_CLEAR, CHAR_W'($urandom));
          repeat ($urandom_range(0, 12)) send(CMD_KEY, key_byte());
          send(CMD_KEY_DONE, CHAR_W'($urandom));
        end
        repeat ($urandom_range(1, 3)) begin
          repeat ($urandom_range(0, 14)) send(CMD_TEXT, text_byte());
          send(CMD_END, CHAR_W'($urandom));
        end
      end else begin
        repeat ($urandom_range(3, 10)) send(CMD_W'($urandom), CHAR_W'($urandom));
      end
      if ($urandom_range(0, 24) == 0) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/pfe_pkg.sv
rtl/core/pfe_ram.sv
rtl/core/pfe_datapath.sv
rtl/core/pfe_ctrl.sv
rtl/core/playfair_digraph_encryptor_top.sv
rtl/core/pfe_checker.sv
test/tb.sv
